// File: sv/assert_macros.svh
// Assertion shorthands for the fan curve checker.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked at the same edge as the antecedent.
`define FCC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked at the next edge after the antecedent.
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fcc_pkg.sv
// Shared types and constants of the fan curve controller.
// No dependencies; compiled before every other file.
package fcc_pkg;

	localparam int TEMP_W     = 13;
	localparam int DELTA_W    = 12;
	localparam int WEIGHT_W   = 9;
	localparam int DUTY_W     = 10;
	localparam int FAULT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam int WEIGHT_FRAC_BITS_DEF = 8;

	// quotient bits; duty never exceeds 2**DUTY_W-1, so larger quotients saturate
	localparam int QUO_W        = DUTY_W;
	localparam int FRONT_STAGES = 7;
	// front stages, divider stages (setup plus one per bit), output stage
	localparam int PIPE_DEPTH   = FRONT_STAGES + QUO_W + 2;

	localparam logic [DELTA_W-1:0]  MIN_DELTA_RST    = 12'd32;
	localparam logic [DELTA_W-1:0]  MAX_DELTA_RST    = 12'd240;
	localparam logic [TEMP_W-1:0]   BASE_WATER_RST   = 13'd480;
	localparam logic [TEMP_W-1:0]   MAX_WATER_RST    = 13'd720;
	localparam logic [WEIGHT_W-1:0] DELTA_WEIGHT_RST = 9'd179;
	localparam logic [WEIGHT_W-1:0] WATER_WEIGHT_RST = 9'd77;
	localparam logic [DUTY_W-1:0]   MIN_DUTY_RST     = 10'd200;
	localparam logic [DUTY_W-1:0]   MAX_DUTY_RST     = 10'd1000;

	typedef enum logic [FAULT_W-1:0] {
		FS_NONE        = 3'd0,
		FS_INLET_BAD   = 3'd1,
		FS_OUTLET_BAD  = 3'd2,
		FS_AMBIENT_BAD = 3'd3,
		FS_COOLANT_BAD = 3'd4
	} fault_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_DELTA    = 3'd0,
		REG_MAX_DELTA    = 3'd1,
		REG_BASE_WATER   = 3'd2,
		REG_MAX_WATER    = 3'd3,
		REG_DELTA_WEIGHT = 3'd4,
		REG_WATER_WEIGHT = 3'd5,
		REG_MIN_DUTY     = 3'd6,
		REG_MAX_DUTY     = 3'd7
	} cfg_reg_t;

	// per-item side information that rides alongside the arithmetic
	typedef struct packed {
		logic               fault;
		fault_t             status;
		logic [DELTA_W-1:0] delta;
	} fcc_side_t;

endpackage

// File: sv/fcc_in_if.sv
// Sensor sample channel: valid/ready plus the three readings and flags.
// Depends on fcc_pkg.
interface fcc_in_if;
	import fcc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] ambient_temp;
	logic                     ambient_ok;
	logic signed [TEMP_W-1:0] inlet_temp;
	logic                     inlet_ok;
	logic signed [TEMP_W-1:0] outlet_temp;
	logic                     outlet_ok;

	modport source (
		output valid, ambient_temp, ambient_ok, inlet_temp, inlet_ok,
			outlet_temp, outlet_ok,
		input  ready
	);

	modport sink (
		input  valid, ambient_temp, ambient_ok, inlet_temp, inlet_ok,
			outlet_temp, outlet_ok,
		output ready
	);
endinterface

// File: sv/fcc_out_if.sv
// Duty result channel: valid/ready plus duty, delta and fault status.
// Depends on fcc_pkg.
interface fcc_out_if;
	import fcc_pkg::*;

	logic               valid;
	logic               ready;
	logic [DUTY_W-1:0]  fan_duty;
	logic [DELTA_W-1:0] delta_temp;
	logic [FAULT_W-1:0] fault_status;

	modport source (
		output valid, fan_duty, delta_temp, fault_status,
		input  ready
	);

	modport sink (
		input  valid, fan_duty, delta_temp, fault_status,
		output ready
	);
endinterface

// File: sv/fcc_div.sv
// Pipelined restoring divider with saturation, one quotient bit per stage.
// Depends on fcc_pkg for the side-information struct.
module fcc_div #(
	parameter int N_W = 51,
	parameter int D_W = 34,
	parameter int Q_W = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [N_W-1:0]  in_n,
	input  logic [D_W-1:0]         in_d,
	input  fcc_pkg::fcc_side_t     in_side,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [Q_W-1:0]         out_q,
	output logic                   out_neg,
	output logic                   out_sat,
	output fcc_pkg::fcc_side_t     out_side
);
	import fcc_pkg::*;

	localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

	// all arrays indexed by divider stage; stage 0 is setup
	logic            vld_q  [0:Q_W];
	logic            en     [0:Q_W];
	logic [CW-1:0]   rem_q  [0:Q_W];
	logic [D_W-1:0]  d_q    [0:Q_W];
	logic [Q_W-1:0]  quo_q  [0:Q_W];
	logic            neg_q  [0:Q_W];
	logic            sat_q  [0:Q_W];
	fcc_side_t       side_q [0:Q_W];

	// stage advances when empty or when the next one advances
	always_comb begin
		en[Q_W] = !vld_q[Q_W] || out_ready;
		for (int k = Q_W - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	// setup: sign, saturation against d * 2**Q_W, start remainder
	logic [CW-1:0] rem0;
	logic [CW-1:0] dlim;
	always_comb begin
		rem0 = in_n[N_W-1] ? '0 : CW'($unsigned(in_n));
		dlim = CW'(in_d);
		dlim = dlim << Q_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en[0]) begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_q[0]  <= rem0;
			d_q[0]    <= in_d;
			quo_q[0]  <= '0;
			neg_q[0]  <= in_n[N_W-1];
			sat_q[0]  <= !in_n[N_W-1] && (rem0 >= dlim);
			side_q[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_bit
		logic [CW-1:0] dsh;
		logic          take;

		always_comb begin
			dsh  = CW'(d_q[k-1]);
			dsh  = dsh << (Q_W - k);
			take = !sat_q[k-1] && (rem_q[k-1] >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en[k]) begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_q[k]         <= take ? rem_q[k-1] - dsh : rem_q[k-1];
				quo_q[k]         <= quo_q[k-1];
				quo_q[k][Q_W-k]  <= take;
				d_q[k]           <= d_q[k-1];
				neg_q[k]         <= neg_q[k-1];
				sat_q[k]         <= sat_q[k-1];
				side_q[k]        <= side_q[k-1];
			end
		end
	end

	assign out_valid = vld_q[Q_W];
	assign out_q     = quo_q[Q_W];
	assign out_neg   = neg_q[Q_W];
	assign out_sat   = sat_q[Q_W];
	assign out_side  = side_q[Q_W];

endmodule

// File: sv/fan_curve_controller.sv
// Fan curve controller top level: sensor triple in, fan duty out.
// Depends on fcc_pkg, fcc_in_if, fcc_out_if and fcc_div.
//
// Channel   Dir  Payload                                        Transfer
// sample    in   ambient/inlet/outlet temp + ok flags           valid & ready
// result    out  fan_duty, delta_temp, fault_status             valid & ready
// cfg       in   cfg_idx, cfg_data (registers 0..7)             cfg_we
//
// The pipeline has 7 front stages (select, factors, two multiply levels,
// sum, scale, dividend), 11 divider stages (setup plus one quotient bit
// per stage) and the output register. One transfer per cycle unless result
// stalls. Each stage holds its item while the one after it is full and
// stalled, so bubbles close up; a stall on result backs up into sample.ready.
// Reset clears the valid bits and loads the register defaults; no sweep.
module fan_curve_controller #(
	parameter int WEIGHT_FRAC_BITS = fcc_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fcc_in_if.sink                          sample,
	fcc_out_if.source                       result,
	input  logic                            cfg_we,
	input  logic [fcc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [fcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fcc_pkg::*;

	// arithmetic widths
	localparam int PD_W   = WEIGHT_W + 1 + TEMP_W + 1;      // wd * nd, signed
	localparam int PW_W   = WEIGHT_W + TEMP_W;              // ww * nw
	localparam int DEN0_W = DELTA_W + TEMP_W;               // dd * dw
	localparam int T1_W   = PD_W + TEMP_W + 1;              // wd * nd * dw, signed
	localparam int T2_W   = PW_W + DELTA_W;                 // ww * nw * dd
	localparam int SUM_W  = T1_W + 1;
	localparam int NUM_W  = SUM_W + DUTY_W + 1;             // times duty span
	localparam int D_W    = DEN0_W + WEIGHT_FRAC_BITS + 1;  // 2 * den
	localparam int N_W    = ((NUM_W + 1 > D_W) ? NUM_W + 1 : D_W) + 1;

	//------------------------------------------------------------------
	// Configuration registers
	//------------------------------------------------------------------
	logic [DELTA_W-1:0]        min_delta_q, max_delta_q;
	logic signed [TEMP_W-1:0]  base_water_q, max_water_q;
	logic [WEIGHT_W-1:0]       delta_weight_q, water_weight_q;
	logic [DUTY_W-1:0]         min_duty_q, max_duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delta_q    <= MIN_DELTA_RST;
			max_delta_q    <= MAX_DELTA_RST;
			base_water_q   <= BASE_WATER_RST;
			max_water_q    <= MAX_WATER_RST;
			delta_weight_q <= DELTA_WEIGHT_RST;
			water_weight_q <= WATER_WEIGHT_RST;
			min_duty_q     <= MIN_DUTY_RST;
			max_duty_q     <= MAX_DUTY_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MIN_DELTA:    min_delta_q    <= cfg_data[DELTA_W-1:0];
				REG_MAX_DELTA:    max_delta_q    <= cfg_data[DELTA_W-1:0];
				REG_BASE_WATER:   base_water_q   <= cfg_data[TEMP_W-1:0];
				REG_MAX_WATER:    max_water_q    <= cfg_data[TEMP_W-1:0];
				REG_DELTA_WEIGHT: delta_weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_WATER_WEIGHT: water_weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_MIN_DUTY:     min_duty_q     <= cfg_data[DUTY_W-1:0];
				REG_MAX_DUTY:     max_duty_q     <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Stage handshake: a stage loads when empty or when the next loads
	//------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s19;
	logic en1, en2, en3, en4, en5, en6, en7, en19;
	logic div_in_ready, div_out_valid;

	assign en19 = !vld_s19 || result.ready;
	assign en7  = !vld_s7 || div_in_ready;
	assign en6  = !vld_s6 || en7;
	assign en5  = !vld_s5 || en6;
	assign en4  = !vld_s4 || en5;
	assign en3  = !vld_s3 || en4;
	assign en2  = !vld_s2 || en3;
	assign en1  = !vld_s1 || en2;

	assign sample.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s19 <= 1'b0;
		end else begin
			if (en1)  vld_s1  <= sample.valid;
			if (en2)  vld_s2  <= vld_s1;
			if (en3)  vld_s3  <= vld_s2;
			if (en4)  vld_s4  <= vld_s3;
			if (en5)  vld_s5  <= vld_s4;
			if (en6)  vld_s6  <= vld_s5;
			if (en7)  vld_s7  <= vld_s6;
			if (en19) vld_s19 <= div_out_valid;
		end
	end

	//------------------------------------------------------------------
	// S1: fault decode, water pick, delta clamped to 0..4095
	//------------------------------------------------------------------
	fcc_side_t                side_c1, side_s1;
	logic signed [TEMP_W-1:0] water_c1, water_s1;
	logic signed [TEMP_W:0]   diff_c1;

	always_comb begin
		side_c1.fault = !sample.ambient_ok || (!sample.inlet_ok && !sample.outlet_ok);
		if (!sample.ambient_ok) begin
			side_c1.status = FS_AMBIENT_BAD;
		end else if (!sample.inlet_ok && !sample.outlet_ok) begin
			side_c1.status = FS_COOLANT_BAD;
		end else if (sample.inlet_ok && sample.outlet_ok) begin
			side_c1.status = FS_NONE;
		end else if (sample.inlet_ok) begin
			side_c1.status = FS_OUTLET_BAD;
		end else begin
			side_c1.status = FS_INLET_BAD;
		end

		if (sample.inlet_ok && sample.outlet_ok) begin
			water_c1 = (sample.inlet_temp > sample.outlet_temp) ?
				sample.inlet_temp : sample.outlet_temp;
		end else if (sample.inlet_ok) begin
			water_c1 = sample.inlet_temp;
		end else begin
			water_c1 = sample.outlet_temp;
		end

		diff_c1 = {water_c1[TEMP_W-1], water_c1} -
			{sample.ambient_temp[TEMP_W-1], sample.ambient_temp};
		// negative clamps to zero, 4096 and up saturates at all ones
		if (side_c1.fault || diff_c1[TEMP_W]) begin
			side_c1.delta = '0;
		end else if (diff_c1[TEMP_W-1]) begin
			side_c1.delta = '1;
		end else begin
			side_c1.delta = diff_c1[DELTA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			side_s1  <= side_c1;
			water_s1 <= water_c1;
		end
	end

	//------------------------------------------------------------------
	// S2: factor numerators and positive spans
	//------------------------------------------------------------------
	logic [DELTA_W-1:0]        dv_c2;
	logic signed [DELTA_W+1:0] nd_x, dd_x;
	logic signed [TEMP_W+1:0]  nw_x, dw_x;
	fcc_side_t                 side_s2;
	logic signed [TEMP_W-1:0]  nd_s2;
	logic [DELTA_W-1:0]        dd_s2;
	logic [TEMP_W-1:0]         nw_s2, dw_s2;

	always_comb begin
		dv_c2 = (side_s1.delta < min_delta_q) ? min_delta_q : side_s1.delta;
		nd_x  = $signed({2'b00, dv_c2 - min_delta_q});
		dd_x  = $signed({2'b00, max_delta_q}) - $signed({2'b00, min_delta_q});
		if (dd_x == '0) begin
			nd_x = 14'sd1;
			dd_x = 14'sd1;
		end else if (dd_x < 0) begin
			nd_x = -nd_x;
			dd_x = -dd_x;
		end
		// delta factor capped at one only; it may go negative
		if (nd_x > dd_x) begin
			nd_x = dd_x;
		end

		nw_x = {{2{water_s1[TEMP_W-1]}}, water_s1} -
			{{2{base_water_q[TEMP_W-1]}}, base_water_q};
		dw_x = {{2{max_water_q[TEMP_W-1]}}, max_water_q} -
			{{2{base_water_q[TEMP_W-1]}}, base_water_q};
		if (dw_x == '0) begin
			nw_x = 15'sd1;
			dw_x = 15'sd1;
		end else if (dw_x < 0) begin
			nw_x = -nw_x;
			dw_x = -dw_x;
		end
		// water factor clamped to 0..1
		if (nw_x > dw_x) begin
			nw_x = dw_x;
		end
		if (nw_x < 0) begin
			nw_x = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			side_s2 <= side_s1;
			nd_s2   <= nd_x[TEMP_W-1:0];
			dd_s2   <= dd_x[DELTA_W-1:0];
			nw_s2   <= nw_x[TEMP_W-1:0];
			dw_s2   <= dw_x[TEMP_W-1:0];
		end
	end

	//------------------------------------------------------------------
	// S3: weight products and span product
	//------------------------------------------------------------------
	fcc_side_t              side_s3;
	logic signed [PD_W-1:0] pd_c3, pd_s3;
	logic [PW_W-1:0]        pw_c3, pw_s3;
	logic [DEN0_W-1:0]      den0_c3, den0_s3;
	logic [DELTA_W-1:0]     dd_s3;
	logic [TEMP_W-1:0]      dw_s3;

	always_comb begin
		pd_c3   = $signed({1'b0, delta_weight_q}) * nd_s2;
		pw_c3   = water_weight_q * nw_s2;
		den0_c3 = dd_s2 * dw_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			side_s3 <= side_s2;
			pd_s3   <= pd_c3;
			pw_s3   <= pw_c3;
			den0_s3 <= den0_c3;
			dd_s3   <= dd_s2;
			dw_s3   <= dw_s2;
		end
	end

	//------------------------------------------------------------------
	// S4: cross-multiply each term by the other factor's span
	//------------------------------------------------------------------
	fcc_side_t              side_s4;
	logic signed [T1_W-1:0] t1_c4, t1_s4;
	logic [T2_W-1:0]        t2_c4, t2_s4;
	logic [DEN0_W-1:0]      den0_s4;

	always_comb begin
		t1_c4 = pd_s3 * $signed({1'b0, dw_s3});
		t2_c4 = pw_s3 * dd_s3;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			side_s4 <= side_s3;
			t1_s4   <= t1_c4;
			t2_s4   <= t2_c4;
			den0_s4 <= den0_s3;
		end
	end

	//------------------------------------------------------------------
	// S5: weighted sum
	//------------------------------------------------------------------
	fcc_side_t               side_s5;
	logic signed [SUM_W-1:0] sum_s5;
	logic [DEN0_W-1:0]       den0_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			side_s5 <= side_s4;
			sum_s5  <= t1_s4 + $signed({{(SUM_W - T2_W){1'b0}}, t2_s4});
			den0_s5 <= den0_s4;
		end
	end

	//------------------------------------------------------------------
	// S6: scale by the duty span
	//------------------------------------------------------------------
	fcc_side_t               side_s6;
	logic signed [DUTY_W:0]  span_c6;
	logic signed [NUM_W-1:0] num_c6, num_s6;
	logic [DEN0_W-1:0]       den0_s6;

	always_comb begin
		span_c6 = $signed({1'b0, max_duty_q}) - $signed({1'b0, min_duty_q});
		num_c6  = sum_s5 * span_c6;
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			side_s6 <= side_s5;
			num_s6  <= num_c6;
			den0_s6 <= den0_s5;
		end
	end

	//------------------------------------------------------------------
	// S7: rounding dividend 2*num + den and divisor 2*den
	//------------------------------------------------------------------
	fcc_side_t             side_s7;
	logic signed [N_W-1:0] num_ext, n_c7, n_s7;
	logic [N_W-1:0]        den_ext;
	logic [D_W-1:0]        d_s7;

	always_comb begin
		num_ext = N_W'(num_s6);
		den_ext = N_W'({den0_s6, {WEIGHT_FRAC_BITS{1'b0}}});
		n_c7    = (num_ext <<< 1) + $signed(den_ext);
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			side_s7 <= side_s6;
			n_s7    <= n_c7;
			d_s7    <= {den0_s6, {(WEIGHT_FRAC_BITS + 1){1'b0}}};
		end
	end

	//------------------------------------------------------------------
	// Divider: floor quotient, with a saturation flag for quotients above 2**QUO_W - 1
	//------------------------------------------------------------------
	logic [QUO_W-1:0] div_q;
	logic             div_neg, div_sat;
	fcc_side_t        div_side;

	fcc_div #(
		.N_W (N_W),
		.D_W (D_W),
		.Q_W (QUO_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s7),
		.in_ready  (div_in_ready),
		.in_n      (n_s7),
		.in_d      (d_s7),
		.in_side   (side_s7),
		.out_valid (div_out_valid),
		.out_ready (en19),
		.out_q     (div_q),
		.out_neg   (div_neg),
		.out_sat   (div_sat),
		.out_side  (div_side)
	);

	//------------------------------------------------------------------
	// S19: duty clamp and output register
	//------------------------------------------------------------------
	logic [DUTY_W-1:0]  duty_c19, duty_s19;
	logic [DUTY_W:0]    speed_c19;
	logic [DELTA_W-1:0] delta_s19;
	logic [FAULT_W-1:0] status_s19;

	always_comb begin
		speed_c19 = {1'b0, min_duty_q} + {1'b0, div_q};
		if (div_side.fault || div_sat) begin
			duty_c19 = max_duty_q;
		end else if (div_neg) begin
			// below the floor: min_duty, then the ceiling still wins
			duty_c19 = (min_duty_q > max_duty_q) ? max_duty_q : min_duty_q;
		end else if (speed_c19 > {1'b0, max_duty_q}) begin
			duty_c19 = max_duty_q;
		end else begin
			duty_c19 = speed_c19[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en19) begin
			duty_s19   <= duty_c19;
			delta_s19  <= div_side.delta;
			status_s19 <= div_side.status;
		end
	end

	assign result.valid        = vld_s19;
	assign result.fan_duty     = duty_s19;
	assign result.delta_temp   = delta_s19;
	assign result.fault_status = status_s19;

endmodule

// File: sv/fcc_chk.sv
// Port-level checker for the fan curve controller, bound to the top level.
// Depends on fcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fcc_pkg::DUTY_W-1:0]    fan_duty,
	input logic [fcc_pkg::DELTA_W-1:0]   delta_temp,
	input logic [fcc_pkg::FAULT_W-1:0]   fault_status
);
	import fcc_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

	logic             in_xfer, out_xfer;
	logic [CNT_W-1:0] cnt_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// items accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);
		end
	end

	`FCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fan_duty) && $stable(delta_temp) && $stable(fault_status), "stalled result changed or dropped")
	`FCC_ASSERT_SAME(a_no_phantom, out_valid, cnt_q != '0, "result without an accepted sample")
	`FCC_ASSERT_SAME(a_capacity, 1'b1, cnt_q <= CNT_W'(PIPE_DEPTH), "more items in flight than stages")
	`FCC_ASSERT_SAME(a_ready_flow, out_ready, in_ready, "sample stalled while result side drains")
	`FCC_ASSERT_SAME(a_fault_delta, out_valid && (fault_status == FS_AMBIENT_BAD || fault_status == FS_COOLANT_BAD), delta_temp == '0, "nonzero delta on sensor fault")

endmodule

bind fan_curve_controller fcc_chk u_fcc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.fan_duty     (result.fan_duty),
	.delta_temp   (result.delta_temp),
	.fault_status (result.fault_status)
);
